>>> rtl/maximal_mask_filter_assert.svh
// assertion macros used by the checker file
`ifndef MAXIMAL_MASK_FILTER_ASSERT_SVH
`define MAXIMAL_MASK_FILTER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MMF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mmf check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define MMF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mmf check failed");

`endif

>>> rtl/mmf_pkg.sv
// shared types, widths and helpers of the maximal mask filter
package mmf_pkg;

  localparam int WORD_W = 64;
  localparam int CNT_W  = 7;

  typedef struct packed {
    logic [WORD_W-1:0] point_x_bits;
    logic [WORD_W-1:0] point_y_bits;
    logic [WORD_W-1:0] disc_mask;
    logic              last_item;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] kept_x_bits;
    logic [WORD_W-1:0] kept_y_bits;
    logic [WORD_W-1:0] kept_mask;
    logic [CNT_W-1:0]  member_count;
    logic              final_result;
    logic              overflowed;
  } out_item_t;

  // one stored candidate
  typedef struct packed {
    logic [WORD_W-1:0] pt_x;
    logic [WORD_W-1:0] pt_y;
    logic [WORD_W-1:0] mask;
    logic [CNT_W-1:0]  count;
  } cand_t;

  // pairwise adder tree, six levels for the 64-bit word
  function automatic logic [CNT_W-1:0] popcnt(input logic [WORD_W-1:0] v);
    logic [1:0] s2  [32];
    logic [2:0] s4  [16];
    logic [3:0] s8  [8];
    logic [4:0] s16 [4];
    logic [5:0] s32 [2];
    for (int i = 0; i < 32; i++) begin
      s2[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 16; i++) begin
      s4[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      s8[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      s16[i] = {1'b0, s8[2*i]} + {1'b0, s8[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      s32[i] = {1'b0, s16[2*i]} + {1'b0, s16[2*i+1]};
    end
    return {1'b0, s32[0]} + {1'b0, s32[1]};
  endfunction

endpackage

>>> rtl/maximal_mask_filter.sv
// top level of the maximal mask filter: load, order by count, subset filter, emit
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_stall   mmf_pkg::in_item_t
//   out_      output     out_valid / out_stall mmf_pkg::out_item_t
//   cfg_      input      cfg_wr_en             cfg_wr_data (filter_enable)
//
// loading takes one cycle per transaction; the candidate store has one write port
// after the last item the input stalls while the set is worked off the store:
//   filter on: per distinct count value, highest first, a pick step, then each stored
//   candidate is read and tested on count; a match is compared against each survivor
//   in turn and kept if none covers it; filter off: each candidate is read and kept
// out_stall holds the output register; a survivor behind a held result stalls the work,
// and the next set loads while the final result waits; rst_n is synchronous, clears
// control state and sets filter_enable to 1
module maximal_mask_filter #(
  parameter int MAX_CANDIDATES = 64,
  parameter int DISC_COUNT     = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  mmf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mmf_pkg::out_item_t out_data
);
  import mmf_pkg::*;

  localparam int IDX_W  = $clog2(MAX_CANDIDATES);
  localparam int FILL_W = $clog2(MAX_CANDIDATES + 1);
  localparam int LVL_W  = $clog2(DISC_COUNT + 1);

  typedef enum logic [7:0] {
    S_LOAD = 8'b0000_0001,  // taking transactions
    S_PICK = 8'b0000_0010,  // choose highest count still present
    S_SCAN = 8'b0000_0100,  // store read in flight
    S_TEST = 8'b0000_1000,  // store data back, match on count if filtering
    S_CRD  = 8'b0001_0000,  // survivor list read in flight
    S_CCMP = 8'b0010_0000,  // subset test against one survivor
    S_KEEP = 8'b0100_0000,  // new survivor: push out the previous one
    S_LAST = 8'b1000_0000   // flush the final survivor
  } state_t;

  state_t            state_r, state_nxt;
  logic              filter_en_r;          // config register
  logic              fen_r, fen_nxt;       // filter mode sampled at the last item
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              drop_r, drop_nxt;
  logic [DISC_COUNT:0] present_r, present_nxt;  // counts seen in this set
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [IDX_W-1:0]  kidx_r, kidx_nxt;
  logic [FILL_W-1:0] kn_r, kn_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  cand_t             pend_r, pend_nxt;
  cand_t             cur_r, cur_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic              in_acc;
  logic              store_we;
  logic [CNT_W-1:0]  st_count;
  cand_t             rd_cand;
  logic              covered;
  logic              kept_we;
  logic              slot_free;
  logic              keep_go;
  logic [IDX_W-1:0]  last_idx;
  logic [LVL_W-1:0]  top_lvl;
  state_t            adv_state;
  logic [IDX_W-1:0]  adv_idx;
  logic [DISC_COUNT:0] adv_present;

  assign in_stall  = (state_r != S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign store_we  = in_acc && (fill_r < FILL_W'(MAX_CANDIDATES));
  assign slot_free = !out_valid_r || !out_stall;
  assign keep_go   = !pend_valid_r || slot_free;
  assign kept_we   = (state_r == S_KEEP) && keep_go && fen_r;
  assign last_idx  = IDX_W'(fill_r - 1'b1);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  mmf_store #(
    .MAX_CANDIDATES (MAX_CANDIDATES),
    .DISC_COUNT     (DISC_COUNT),
    .ADDR_W         (IDX_W)
  ) u_store (
    .clk      (clk),
    .wr_en    (store_we),
    .wr_addr  (fill_r[IDX_W-1:0]),
    .wr_item  (in_data),
    .wr_count (st_count),
    .rd_addr  (idx_r),
    .rd_cand  (rd_cand)
  );

  mmf_kept #(
    .DEPTH  (MAX_CANDIDATES),
    .ADDR_W (IDX_W)
  ) u_kept (
    .clk        (clk),
    .wr_en      (kept_we),
    .wr_addr    (kn_r[IDX_W-1:0]),
    .wr_mask    (cur_r.mask),
    .rd_addr    (kidx_r),
    .probe_mask (cur_r.mask),
    .covered    (covered)
  );

  // highest count value still waiting for its pass
  always_comb begin
    top_lvl = '0;
    for (int i = 0; i <= DISC_COUNT; i++) begin
      if (present_r[i]) begin
        top_lvl = LVL_W'(i);
      end
    end
  end

  // step to the next stored candidate, or finish the current pass
  always_comb begin
    adv_present = present_r;
    adv_idx     = idx_r;
    if (idx_r == last_idx) begin
      if (fen_r) begin
        adv_present[lvl_r] = 1'b0;
        adv_state          = S_PICK;
      end else begin
        adv_state = S_LAST;
      end
    end else begin
      adv_idx   = idx_r + 1'b1;
      adv_state = S_SCAN;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    fen_nxt        = fen_r;
    fill_nxt       = fill_r;
    drop_nxt       = drop_r;
    present_nxt    = present_r;
    idx_nxt        = idx_r;
    lvl_nxt        = lvl_r;
    kidx_nxt       = kidx_r;
    kn_nxt         = kn_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    cur_nxt        = cur_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (store_we) begin
            fill_nxt                         = fill_r + 1'b1;
            present_nxt[st_count[LVL_W-1:0]] = 1'b1;
          end else begin
            // store full: transaction dropped, still may end the set
            drop_nxt = 1'b1;
          end
          if (in_data.last_item) begin
            fen_nxt = filter_en_r;
            idx_nxt = '0;
            if (filter_en_r) begin
              state_nxt = S_PICK;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        end
      end

      S_PICK: begin
        if (present_r == '0) begin
          state_nxt = S_LAST;
        end else begin
          lvl_nxt   = top_lvl;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        state_nxt = S_TEST;
      end

      S_TEST: begin
        if (!fen_r || (rd_cand.count == CNT_W'(lvl_r))) begin
          cur_nxt = rd_cand;
          if (fen_r && (kn_r != '0)) begin
            kidx_nxt  = '0;
            state_nxt = S_CRD;
          end else begin
            state_nxt = S_KEEP;
          end
        end else begin
          idx_nxt     = adv_idx;
          present_nxt = adv_present;
          state_nxt   = adv_state;
        end
      end

      S_CRD: begin
        state_nxt = S_CCMP;
      end

      S_CCMP: begin
        if (covered) begin
          idx_nxt     = adv_idx;
          present_nxt = adv_present;
          state_nxt   = adv_state;
        end else if (kidx_r == IDX_W'(kn_r - 1'b1)) begin
          state_nxt = S_KEEP;
        end else begin
          kidx_nxt  = kidx_r + 1'b1;
          state_nxt = S_CRD;
        end
      end

      S_KEEP: begin
        if (keep_go) begin
          if (fen_r) begin
            kn_nxt = kn_r + 1'b1;
          end
          // previous survivor is not the final one: emit it now
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_nxt = '{kept_x_bits:  pend_r.pt_x,
                        kept_y_bits:  pend_r.pt_y,
                        kept_mask:    pend_r.mask,
                        member_count: pend_r.count,
                        final_result: 1'b0,
                        overflowed:   drop_r};
          end
          pend_valid_nxt = 1'b1;
          pend_nxt       = cur_r;
          idx_nxt        = adv_idx;
          present_nxt    = adv_present;
          state_nxt      = adv_state;
        end
      end

      S_LAST: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{kept_x_bits:  pend_r.pt_x,
                      kept_y_bits:  pend_r.pt_y,
                      kept_mask:    pend_r.mask,
                      member_count: pend_r.count,
                      final_result: 1'b1,
                      overflowed:   drop_r};
          pend_valid_nxt = 1'b0;
          fill_nxt       = '0;
          drop_nxt       = 1'b0;
          present_nxt    = '0;
          kn_nxt         = '0;
          state_nxt      = S_LOAD;
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      filter_en_r  <= 1'b1;
      fen_r        <= 1'b1;
      fill_r       <= '0;
      drop_r       <= 1'b0;
      present_r    <= '0;
      idx_r        <= '0;
      lvl_r        <= '0;
      kidx_r       <= '0;
      kn_r         <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_wr_en) begin
        filter_en_r <= cfg_wr_data;
      end
      fen_r        <= fen_nxt;
      fill_r       <= fill_nxt;
      drop_r       <= drop_nxt;
      present_r    <= present_nxt;
      idx_r        <= idx_nxt;
      lvl_r        <= lvl_nxt;
      kidx_r       <= kidx_nxt;
      kn_r         <= kn_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

endmodule

>>> rtl/mmf_store.sv
// candidate store: trims and counts the mask on write, one registered read port
module mmf_store #(
  parameter int MAX_CANDIDATES = 64,
  parameter int DISC_COUNT     = 64,
  parameter int ADDR_W         = $clog2(MAX_CANDIDATES)
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [ADDR_W-1:0]       wr_addr,
  input  mmf_pkg::in_item_t       wr_item,
  output logic [mmf_pkg::CNT_W-1:0] wr_count,
  input  logic [ADDR_W-1:0]       rd_addr,
  output mmf_pkg::cand_t          rd_cand
);
  import mmf_pkg::*;

  // only bits of existing discs survive
  localparam logic [WORD_W-1:0] DISC_BITS = {WORD_W{1'b1}} >> (WORD_W - DISC_COUNT);

  cand_t             cand_mem_r [MAX_CANDIDATES];
  cand_t             rd_cand_r;
  logic [WORD_W-1:0] trim_mask;

  assign trim_mask = wr_item.disc_mask & DISC_BITS;
  assign wr_count  = popcnt(trim_mask);
  assign rd_cand   = rd_cand_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cand_mem_r[wr_addr] <= '{pt_x:  wr_item.point_x_bits,
                               pt_y:  wr_item.point_y_bits,
                               mask:  trim_mask,
                               count: wr_count};
    end
    rd_cand_r <= cand_mem_r[rd_addr];
  end

endmodule

>>> rtl/mmf_kept.sv
// survivor mask list with a registered read and the subset test on its output
module mmf_kept #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [mmf_pkg::WORD_W-1:0] wr_mask,
  input  logic [ADDR_W-1:0]         rd_addr,
  input  logic [mmf_pkg::WORD_W-1:0] probe_mask,
  output logic                      covered
);
  import mmf_pkg::*;

  logic [WORD_W-1:0] kept_mem_r [DEPTH];
  logic [WORD_W-1:0] rd_mask_r;

  // probe is covered when it has no bit outside the stored mask
  assign covered = ((probe_mask & ~rd_mask_r) == '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      kept_mem_r[wr_addr] <= wr_mask;
    end
    rd_mask_r <= kept_mem_r[rd_addr];
  end

endmodule

>>> rtl/mmf_checker.sv
// port-level checks of the maximal mask filter and their bind
`include "maximal_mask_filter_assert.svh"

module mmf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input mmf_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input mmf_pkg::out_item_t out_data
);
  import mmf_pkg::*;

  // a held result does not move
  `MMF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // the end of a set always starts the working phase
  `MMF_ASSERT_NEXT(a_last_stalls, in_valid && !in_stall && in_data.last_item, in_stall)

  // member count matches the emitted mask
  `MMF_ASSERT_IMPL(a_count_ok, out_valid,
                   $countones(out_data.kept_mask) == 32'(out_data.member_count))

endmodule

bind maximal_mask_filter mmf_checker u_mmf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
